// File: hdl/pqa_pkg.sv
`timescale 1ns / 1ps

package pqa_pkg;

   // Depth of each of the four request queues.
   localparam int QUEUE_DEPTH = 16;
   localparam int NUM_QUEUES  = 4;
   localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int QSEL_W      = 2;
   localparam int ADDR_W      = QSEL_W + SLOT_W;
   localparam int MEM_WORDS   = NUM_QUEUES << SLOT_W;

   // Command codes of the input transaction.
   localparam logic CMD_ARRIVE   = 1'b0;
   localparam logic CMD_DISPATCH = 1'b1;

   // Status codes of the result transaction.
   typedef enum logic [1:0] {
      ST_QUEUED = 2'd0,
      ST_FULL   = 2'd1,
      ST_SERVED = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   typedef struct packed {
      logic       command;
      logic [7:0] requester_id;
      logic       goes_east;
      logic       high_priority;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  served_id;
      logic        served_east;
      logic        served_high;
      logic [15:0] served_total;
   } rsp_item_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
   } dp_cmd_type;

endpackage

// File: hdl/pqa_ctrl.sv
`timescale 1ns / 1ps

module pqa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pqa_pkg::dp_cmd_type dp_cmd
);
   import pqa_pkg::*;

   typedef enum logic {
      S_EMPTY,
      S_HOLD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      load;

   // A new transaction is taken when the output slot is free or drains this cycle.
   // Nothing is taken while reset is high.
   assign req_ready   = ~reset & ((state_ff == S_EMPTY) | rsp_ready);
   assign load        = req_valid & req_ready;
   assign dp_cmd.load = load;
   assign rsp_valid   = rsp_valid_ff;

   // Next state: loading fills the output slot, a taken result empties it.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_EMPTY: begin
            if (load) state_in = S_HOLD;
         end
         S_HOLD: begin
            if (load)           state_in = S_HOLD;
            else if (rsp_ready) state_in = S_EMPTY;
         end
         default: state_in = S_EMPTY;
      endcase
      rsp_valid_in = (state_in == S_HOLD);
   end

   // State and registered valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_EMPTY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/pqa_datapath.sv
`timescale 1ns / 1ps

module pqa_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  pqa_pkg::dp_cmd_type   dp_cmd,
   input  pqa_pkg::req_item_type req_data,
   output pqa_pkg::rsp_item_type rsp_data
);
   import pqa_pkg::*;

   logic [7:0]        mem [MEM_WORDS];

   logic [CNT_W-1:0]  count_ff [NUM_QUEUES];
   logic [CNT_W-1:0]  count_in [NUM_QUEUES];
   logic [SLOT_W-1:0] head_ff  [NUM_QUEUES];
   logic [SLOT_W-1:0] head_in  [NUM_QUEUES];
   logic [SLOT_W-1:0] tail_ff  [NUM_QUEUES];
   logic [SLOT_W-1:0] tail_in  [NUM_QUEUES];
   logic              last_east_ff;
   logic              last_east_in;
   logic [15:0]       total_ff;
   logic [15:0]       total_in;

   logic [1:0]        status_ff;
   logic [1:0]        status_in;
   logic              east_ff;
   logic              east_in;
   logic              high_ff;
   logic              high_in;
   logic [7:0]        rd_id_ff;

   logic [QSEL_W-1:0] arr_q;
   logic              arr_full;
   logic              hi_any;
   logic              lo_any;
   logic              lvl;
   logic              w_has;
   logic              e_has;
   logic              dir;
   logic [QSEL_W-1:0] disp_q;
   logic              do_write;
   logic              do_read;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
      if (p == SLOT_W'(QUEUE_DEPTH - 1)) next_slot = '0;
      else                               next_slot = p + SLOT_W'(1);
   endfunction

   // Queue selection for arrivals and for dispatch.
   always_comb begin
      arr_q    = {req_data.high_priority, req_data.goes_east};
      arr_full = (count_ff[arr_q] == CNT_W'(QUEUE_DEPTH));
      hi_any   = (count_ff[2] != '0) | (count_ff[3] != '0);
      lo_any   = (count_ff[0] != '0) | (count_ff[1] != '0);
      lvl      = hi_any;
      w_has    = (count_ff[{lvl, 1'b0}] != '0);
      e_has    = (count_ff[{lvl, 1'b1}] != '0);
      if (w_has & e_has) dir = ~last_east_ff;
      else               dir = e_has;
      disp_q   = {lvl, dir};
      wr_addr  = {arr_q, tail_ff[arr_q]};
      rd_addr  = {disp_q, head_ff[disp_q]};
   end

   // Next values of queue pointers, counters and the result fields.
   always_comb begin
      count_in     = count_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      last_east_in = last_east_ff;
      total_in     = total_ff;
      status_in    = status_ff;
      east_in      = east_ff;
      high_in      = high_ff;
      do_write     = 1'b0;
      do_read      = 1'b0;
      if (dp_cmd.load) begin
         east_in = 1'b0;
         high_in = 1'b0;
         if (req_data.command == CMD_ARRIVE) begin
            if (arr_full) begin
               status_in = ST_FULL;
            end else begin
               do_write        = 1'b1;
               tail_in[arr_q]  = next_slot(tail_ff[arr_q]);
               count_in[arr_q] = count_ff[arr_q] + CNT_W'(1);
               status_in       = ST_QUEUED;
            end
         end else if (hi_any | lo_any) begin
            do_read          = 1'b1;
            head_in[disp_q]  = next_slot(head_ff[disp_q]);
            count_in[disp_q] = count_ff[disp_q] - CNT_W'(1);
            last_east_in     = dir;
            total_in         = total_ff + 16'd1;
            status_in        = ST_SERVED;
            east_in          = dir;
            high_in          = lvl;
         end else begin
            status_in = ST_EMPTY;
         end
      end
   end

   // Queue storage with registered read data.
   always_ff @(posedge clock) begin
      if (do_write) mem[wr_addr] <= req_data.requester_id;
      if (do_read)  rd_id_ff     <= mem[rd_addr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
         end
         last_east_ff <= 1'b1;
         total_ff     <= '0;
      end else begin
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         last_east_ff <= last_east_in;
         total_ff     <= total_in;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      east_ff   <= east_in;
      high_ff   <= high_in;
   end

   // The served id is only meaningful on a dispatch.
   assign rsp_data.status       = status_ff;
   assign rsp_data.served_id    = (status_ff == ST_SERVED) ? rd_id_ff : 8'd0;
   assign rsp_data.served_east  = east_ff;
   assign rsp_data.served_high  = high_ff;
   assign rsp_data.served_total = total_ff;

endmodule

// File: hdl/priority_alternating_queue_arbiter.sv
`timescale 1ns / 1ps
// Channel   Ports                           Payload
// req       req_valid, req_ready, req_data  req_item_type: command, id, direction, priority
// rsp       rsp_valid, rsp_ready, rsp_data  rsp_item_type: status, served fields, total
//
// Each transaction's result appears in the cycle after acceptance; it is held in
// the result register and comes from the registered queue-memory read.
// A new transaction is accepted in the same cycle the pending result is taken,
// so the block sustains one transaction per cycle when rsp_ready stays high.
// While a result waits for rsp_ready, req_ready is low.
// Reset (synchronous, active high) empties all queues and sets the last
// served direction to east; the queue memory itself is not cleared.

module priority_alternating_queue_arbiter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pqa_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pqa_pkg::rsp_item_type rsp_data
);
   import pqa_pkg::*;

   dp_cmd_type dp_cmd;

   // Handshake control.
   pqa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd)
   );

   // Queues, selection and result registers.
   pqa_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .dp_cmd   (dp_cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import pqa_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_data;

   priority_alternating_queue_arbiter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Free-running clock with a 20 ns period.
   always #10 clock = ~clock;

   // Shadow copy of the four queues, the shared direction and the dispatch count.
   logic [7:0]   model_ids [NUM_QUEUES][QUEUE_DEPTH];
   int           model_head [NUM_QUEUES] = '{default: 0};
   int           model_tail [NUM_QUEUES] = '{default: 0};
   int           model_count [NUM_QUEUES] = '{default: 0};
   logic         model_last_east = 1'b1;
   logic [15:0]  model_total = '0;

   rsp_item_type pending_grants[$];
   int           mismatch_count = 0;

   // Receiver stall pattern: modes of random length, one of them never stalls.
   int           ready_mode = 0;
   int           ready_left = 0;
   logic [7:0]   ready_word = 8'h5b;

   // Work out the result of one accepted transaction and advance the shadow state.
   function automatic rsp_item_type predict_grant(input req_item_type item);
      rsp_item_type r;
      logic [1:0]   qsel;
      logic         level;
      logic         dir;
      logic         w_has;
      logic         e_has;
      r = '0;
      if (item.command == CMD_ARRIVE) begin
         qsel = {item.high_priority, item.goes_east};
         if (model_count[qsel] >= QUEUE_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            model_ids[qsel][model_tail[qsel]] = item.requester_id;
            model_tail[qsel] = (model_tail[qsel] + 1) % QUEUE_DEPTH;
            model_count[qsel]++;
            r.status = ST_QUEUED;
         end
      end else if (model_count[0] == 0 && model_count[1] == 0 &&
                   model_count[2] == 0 && model_count[3] == 0) begin
         r.status = ST_EMPTY;
      end else begin
         // High pair wins; inside a pair, alternate when both sides wait.
         level = (model_count[2] != 0) || (model_count[3] != 0);
         w_has = model_count[{level, 1'b0}] != 0;
         e_has = model_count[{level, 1'b1}] != 0;
         dir = (w_has && e_has) ? !model_last_east : e_has;
         qsel = {level, dir};
         r.served_id = model_ids[qsel][model_head[qsel]];
         model_head[qsel] = (model_head[qsel] + 1) % QUEUE_DEPTH;
         model_count[qsel]--;
         r.served_east = dir;
         r.served_high = level;
         model_last_east = dir;
         model_total = model_total + 16'd1;
         r.status = ST_SERVED;
      end
      r.served_total = model_total;
      return r;
   endfunction

   // Present one transaction, hold it until accepted, then record its expected result.
   task automatic send_request(input req_item_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      pending_grants.push_back(predict_grant(item));
   endtask

   task automatic idle_for(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold off the sender until every outstanding result has been taken.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_grants.size() != 0);
   endtask

   function automatic req_item_type make_arrive(input logic [7:0] id, input logic east,
                                                input logic high);
      req_item_type item;
      item.command       = CMD_ARRIVE;
      item.requester_id  = id;
      item.goes_east     = east;
      item.high_priority = high;
      return item;
   endfunction

   // Dispatch carries random values in the fields it ignores.
   function automatic req_item_type make_dispatch();
      req_item_type item;
      item.command       = CMD_DISPATCH;
      item.requester_id  = 8'($urandom_range(0, 255));
      item.goes_east     = 1'($urandom_range(0, 1));
      item.high_priority = 1'($urandom_range(0, 1));
      return item;
   endfunction

   // A dispatch with nothing queued must leave the count and direction alone.
   task automatic test_empty_dispatch();
      send_request(make_dispatch());
   endtask

   // Extreme ids in all four queues, then high before low with alternation in each pair.
   task automatic test_extremes();
      send_request(make_arrive(8'h00, 1'b0, 1'b0));
      send_request(make_arrive(8'hff, 1'b1, 1'b1));
      send_request(make_arrive(8'h80, 1'b0, 1'b1));
      send_request(make_arrive(8'h7f, 1'b1, 1'b0));
      repeat (4) send_request(make_dispatch());
   endtask

   // Fill one queue and push one more so it gets dropped.
   task automatic test_full_queue();
      for (int i = 0; i <= QUEUE_DEPTH; i++) begin
         send_request(make_arrive(8'ha5 ^ i[7:0], 1'b1, 1'b1));
      end
   endtask

   // Phases with their own arrive/dispatch mix and queue bias, sent in random bursts.
   task automatic test_random_traffic(input int target);
      int           sent;
      int           phase;
      int           arrive_pct;
      int           high_pct;
      int           east_pct;
      int           phase_len;
      int           burst_left;
      req_item_type item;
      sent = 0;
      phase = 0;
      burst_left = 0;
      while (sent < target) begin
         case ($urandom_range(0, 3))
            0: begin
               arrive_pct = 85;
            end
            1: begin
               arrive_pct = 50;
            end
            2: begin
               arrive_pct = 20;
            end
            default: begin
               arrive_pct = 65;
            end
         endcase
         high_pct  = $urandom_range(0, 100);
         east_pct  = $urandom_range(0, 100);
         phase_len = $urandom_range(40, 160);
         // The last phase stops at the requested number of transactions.
         if (phase_len > target - sent) phase_len = target - sent;
         repeat (phase_len) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 6));
            end
            if ($urandom_range(1, 100) <= arrive_pct) begin
               item = make_arrive(8'($urandom_range(0, 255)),
                                  $urandom_range(1, 100) <= east_pct,
                                  $urandom_range(1, 100) <= high_pct);
            end else begin
               item = make_dispatch();
            end
            send_request(item);
            sent++;
            burst_left--;
         end
         phase++;
         if (phase % 4 == 0) wait_for_drain();
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Receiver side: pick a stall mode for a random stretch of cycles.
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= $urandom_range(0, 3);
         ready_left <= $urandom_range(8, 80);
         ready_word <= 8'($urandom_range(0, 255)) | 8'h01;
         rsp_ready  <= 1'b1;
      end else begin
         ready_left <= ready_left - 1;
         case (ready_mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_ready  <= ready_word[0];
               ready_word <= {ready_word[0], ready_word[7:1]};
            end
         endcase
      end
   end

   // Compare each taken result with the oldest expected one.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_grants.size() == 0) begin
            $error("unexpected result transaction: status %0d", rsp_data.status);
            mismatch_count++;
         end else begin
            want = pending_grants.pop_front();
            check_field("status", want.status, rsp_data.status);
            check_field("served_id", want.served_id, rsp_data.served_id);
            check_field("served_east", want.served_east, rsp_data.served_east);
            check_field("served_high", want.served_high, rsp_data.served_high);
            check_field("served_total", want.served_total, rsp_data.served_total);
         end
      end
   end

   // Main sequence.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_empty_dispatch();
      test_extremes();
      test_full_queue();
      test_random_traffic(1925);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_grants.size() != 0);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #10ms;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
